### rtl/didc_pkg.sv
// Package for the date interval day counter: microcode types, program and calendar tables.
package didc_pkg;

    // Field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int Q_W     = 8;   // floor(year / 100) for any 14-bit year
    localparam int R_W     = 7;   // year mod 100
    localparam int PC_W    = 3;

    // Calendar constants
    localparam logic [YEAR_W-1:0]  YEAR_LIMIT = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
    // 2^19 / 100 rounded up; exact floor for dividends below 43690
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,  // range checks on month, year, day
        OP_DIV    = 3'd1,  // floor(year / 100)
        OP_LEAP   = 3'd2,  // leap flag, month length check, centuries
        OP_YEARS  = 3'd3,  // 365*y + ceil(y/4)
        OP_CENT   = 3'd4,  // - ceil(y/100) + ceil(y/400)
        OP_MONTH  = 3'd5,  // days before month, leap day, day of month
        OP_STORE  = 3'd6,  // park start day number, move to end date
        OP_FINISH = 3'd7   // difference and result word
    } t_op;

    typedef enum logic [1:0] {
        JC_NONE  = 2'd0,
        JC_BAD   = 2'd1,   // jump when a date has failed a check
        JC_FIRST = 2'd2,   // jump while working on the start date
        JC_END   = 2'd3    // last step of the program
    } t_jc;

    typedef struct packed {
        t_op             op;
        t_jc             jc;
        logic [PC_W-1:0] target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_LOAD   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_FINISH = PC_W'(7);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // Microprogram: one control word per step
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            3'd0:    w = '{OP_LOAD,   JC_NONE,  PC_LOAD};
            3'd1:    w = '{OP_DIV,    JC_NONE,  PC_LOAD};
            3'd2:    w = '{OP_LEAP,   JC_BAD,   PC_FINISH};
            3'd3:    w = '{OP_YEARS,  JC_NONE,  PC_LOAD};
            3'd4:    w = '{OP_CENT,   JC_NONE,  PC_LOAD};
            3'd5:    w = '{OP_MONTH,  JC_NONE,  PC_LOAD};
            3'd6:    w = '{OP_STORE,  JC_FIRST, PC_LOAD};
            3'd7:    w = '{OP_FINISH, JC_END,   PC_LOAD};
            default: w = '{OP_FINISH, JC_END,   PC_LOAD};
        endcase
        return w;
    endfunction

    // Days in a common-year month; 0 for a month code that means nothing
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] l;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                   l = DAY_W'(30);
            4'd2:                                      l = DAY_W'(28);
            default:                                   l = '0;
        endcase
        return l;
    endfunction

    // Days in the year before the first of the month (common year)
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### rtl/date_interval_day_count_top.sv
// Date interval day counter: microcoded sequencer turning two dates into day numbers.
// The program runs 7 steps per date plus one finishing step; when a date fails its
// checks, the program jumps from the leap step straight to the finishing step, so a
// bad start date skips the end date. busy is high while the program runs, so no new
// word is taken until the program has finished. Each result shows for one cycle on
// o_done and the receiver cannot stall. Synchronous active-low reset returns the
// sequencer to idle and clears the result strobe.
module date_interval_day_count_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [didc_pkg::DAY_W-1:0]    i_start_day,
    input  logic [didc_pkg::MONTH_W-1:0]  i_start_month,
    input  logic [didc_pkg::YEAR_W-1:0]   i_start_year,
    input  logic [didc_pkg::DAY_W-1:0]    i_end_day,
    input  logic [didc_pkg::MONTH_W-1:0]  i_end_month,
    input  logic [didc_pkg::YEAR_W-1:0]   i_end_year,
    input  logic                          i_include_end,
    output logic                          o_done,
    output logic [didc_pkg::COUNT_W-1:0]  o_day_count,
    output logic                          o_invalid
);
    import didc_pkg::*;

    // Sequencer state
    t_state            r_state, n_state;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic              r_sel, n_sel;      // 0: start date, 1: end date
    logic              r_done, n_done;

    // Captured input word
    logic [DAY_W-1:0]   r_sd, r_ed;
    logic [MONTH_W-1:0] r_sm, r_em;
    logic [YEAR_W-1:0]  r_sy, r_ey;
    logic               r_inc;

    // Datapath registers
    logic               r_bad, n_bad;
    logic               r_leap, n_leap;
    logic [Q_W-1:0]     r_q, n_q;
    logic [Q_W-1:0]     r_c100, n_c100;
    logic [COUNT_W-1:0] r_acc, n_acc;
    logic [COUNT_W-1:0] r_a, n_a;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_inv, n_inv;

    t_uword             uw;
    logic               accept;

    // Current date operands
    logic [DAY_W-1:0]   cur_d;
    logic [MONTH_W-1:0] cur_m;
    logic [YEAR_W-1:0]  cur_y;

    // Arithmetic terms
    logic [26:0]        div_prod;
    logic [14:0]        q_times_100;
    logic [R_W-1:0]     rem100;
    logic               leap_now;
    logic [DAY_W-1:0]   mlen;
    logic [YEAR_W:0]    y_plus3;
    logic [Q_W:0]       c100_plus3;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign uw     = ucode(r_pc);

    assign cur_d = r_sel ? r_ed : r_sd;
    assign cur_m = r_sel ? r_em : r_sm;
    assign cur_y = r_sel ? r_ey : r_sy;

    assign div_prod    = 27'(cur_y) * 27'(RECIP_100);
    assign q_times_100 = 15'(r_q) * 15'd100;
    assign rem100      = R_W'(15'(cur_y) - q_times_100);
    assign leap_now    = ((cur_y[1:0] == 2'b00) && (rem100 != '0))
                      || ((rem100 == '0) && (r_q[1:0] == 2'b00));
    assign mlen        = month_len(cur_m) + DAY_W'((cur_m == MONTH_FEB) && leap_now);
    assign y_plus3     = {1'b0, cur_y} + (YEAR_W+1)'(3);
    assign c100_plus3  = {1'b0, r_c100} + (Q_W+1)'(3);

    // Datapath: one operation per control word
    always_comb begin
        n_bad  = r_bad;
        n_leap = r_leap;
        n_q    = r_q;
        n_c100 = r_c100;
        n_acc  = r_acc;
        n_a    = r_a;
        n_cnt  = r_cnt;
        n_inv  = r_inv;
        if (accept) begin
            n_bad = 1'b0;
        end else if (r_state == ST_RUN) begin
            case (uw.op)
                OP_LOAD: begin
                    if ((cur_m == '0) || (cur_m > MONTH_DEC) || (cur_y > YEAR_LIMIT)
                        || (cur_d == '0)) begin
                        n_bad = 1'b1;
                    end
                end
                OP_DIV: begin
                    n_q = Q_W'(div_prod >> RECIP_SH);
                end
                OP_LEAP: begin
                    n_leap = leap_now;
                    n_c100 = r_q + Q_W'(rem100 != '0);
                    if (cur_d > mlen) begin
                        n_bad = 1'b1;
                    end
                end
                OP_YEARS: begin
                    n_acc = COUNT_W'(cur_y) * COUNT_W'(365)
                          + COUNT_W'(y_plus3 >> 2);
                end
                OP_CENT: begin
                    n_acc = r_acc - COUNT_W'(r_c100) + COUNT_W'(c100_plus3 >> 2);
                end
                OP_MONTH: begin
                    n_acc = r_acc + COUNT_W'(days_before(cur_m))
                          + COUNT_W'((cur_m > MONTH_FEB) && r_leap)
                          + COUNT_W'(cur_d) - COUNT_W'(1);
                end
                OP_STORE: begin
                    if (!r_sel) begin
                        n_a = r_acc;
                    end
                end
                OP_FINISH: begin
                    n_inv = r_bad;
                    if (r_bad) begin
                        n_cnt = '0;
                    end else if (r_a < r_acc) begin
                        n_cnt = r_acc - r_a + COUNT_W'(r_inc);
                    end else begin
                        n_cnt = COUNT_W'(r_inc);
                    end
                end
                default: begin
                    n_bad = r_bad;
                end
            endcase
        end
    end

    // Sequencer: step counter with conditional jumps
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_sel   = r_sel;
        n_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RUN;
                    n_pc    = PC_LOAD;
                    n_sel   = 1'b0;
                end
            end
            ST_RUN: begin
                n_pc = r_pc + PC_W'(1);
                case (uw.jc)
                    JC_BAD: begin
                        if (n_bad) begin
                            n_pc = uw.target;
                        end
                    end
                    JC_FIRST: begin
                        if (!r_sel) begin
                            n_pc  = uw.target;
                            n_sel = 1'b1;
                        end
                    end
                    JC_END: begin
                        n_state = ST_IDLE;
                        n_pc    = PC_LOAD;
                        n_done  = 1'b1;
                    end
                    default: begin
                        n_pc = r_pc + PC_W'(1);
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
                n_pc    = PC_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= PC_LOAD;
            r_sel   <= 1'b0;
            r_done  <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sel   <= n_sel;
            r_done  <= n_done;
            r_bad   <= n_bad;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sd  <= i_start_day;
            r_sm  <= i_start_month;
            r_sy  <= i_start_year;
            r_ed  <= i_end_day;
            r_em  <= i_end_month;
            r_ey  <= i_end_year;
            r_inc <= i_include_end;
        end
        r_leap <= n_leap;
        r_q    <= n_q;
        r_c100 <= n_c100;
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_cnt  <= n_cnt;
        r_inv  <= n_inv;
    end

    assign o_done      = r_done;
    assign o_day_count = r_cnt;
    assign o_invalid   = r_inv;

endmodule
